>>> hw/rtl/two_state_alignment_column_scorer_top_defines.svh
// Assertion macros for the checker of the alignment column scorer.
// Each macro expects signals named clk and arst_n in the scope where it is used.
`ifndef TWO_STATE_ALIGNMENT_COLUMN_SCORER_TOP_DEFINES_SVH
`define TWO_STATE_ALIGNMENT_COLUMN_SCORER_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TSACS_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TSACS_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> hw/rtl/tsacs_pkg.sv
// Package of the two-state alignment column scorer: widths, codes, item types
// and saturating arithmetic helpers. No dependencies.
package tsacs_pkg;

	localparam int SCORE_BITS    = 32;
	localparam int OUT_BITS      = 32;
	localparam int CMP_BITS      = (SCORE_BITS > OUT_BITS) ? SCORE_BITS : OUT_BITS;
	localparam int REG_BITS      = 16;
	localparam int NUM_REGS      = 6;
	localparam int IDX_BITS      = 3;
	localparam int CHAR_BITS     = 8;
	localparam int FIFO_DEPTH    = 4;
	localparam int FIFO_PTR_BITS = $clog2(FIFO_DEPTH);

	typedef logic signed [SCORE_BITS-1:0] score_t;
	typedef logic signed [OUT_BITS-1:0]   out_score_t;
	typedef logic signed [CMP_BITS-1:0]   cmp_score_t;
	typedef logic signed [REG_BITS-1:0]   reg_val_t;
	typedef logic [CHAR_BITS-1:0]         char_t;

	// Configuration register indexes.
	typedef enum logic [IDX_BITS-1:0] {
		REG_MATCH      = 3'd0,
		REG_MISMATCH   = 3'd1,
		REG_GAP_OPEN   = 3'd2,
		REG_GAP_EXTEND = 3'd3,
		REG_ENTER_CN   = 3'd4,
		REG_LEAVE_CN   = 3'd5
	} reg_idx_t;

	localparam reg_val_t RESET_MATCH      = 16'sd102;
	localparam reg_val_t RESET_MISMATCH   = -16'sd91;
	localparam reg_val_t RESET_GAP_OPEN   = -16'sd772;
	localparam reg_val_t RESET_GAP_EXTEND = -16'sd25;
	localparam reg_val_t RESET_ENTER_CN   = -16'sd1000;
	localparam reg_val_t RESET_LEAVE_CN   = -16'sd1000;

	// Character codes.
	localparam char_t CHAR_GAP = 8'h2D;
	localparam char_t CHAR_A   = 8'h41;
	localparam char_t CHAR_C   = 8'h43;
	localparam char_t CHAR_G   = 8'h47;
	localparam char_t CHAR_T   = 8'h54;

	// Kind of position score a column earns, resolved by the front end.
	typedef enum logic [2:0] {
		PC_ZERO,
		PC_GAP_OPEN,
		PC_GAP_EXTEND,
		PC_MATCH,
		PC_MISMATCH
	} pos_class_t;

	// One classified column as it travels through the queue.
	typedef struct packed {
		pos_class_t pos_class;
		logic       first_column;
		logic       last_column;
	} column_t;

	// Configuration write bundle.
	typedef struct packed {
		logic                wr_en;
		logic [IDX_BITS-1:0] index;
		reg_val_t            data;
	} cfg_wr_t;

	localparam score_t SCORE_MAX = {1'b0, {(SCORE_BITS-1){1'b1}}};
	localparam score_t SCORE_MIN = {1'b1, {(SCORE_BITS-1){1'b0}}};
	localparam out_score_t OUT_MAX = {1'b0, {(OUT_BITS-1){1'b1}}};
	localparam out_score_t OUT_MIN = {1'b1, {(OUT_BITS-1){1'b0}}};

	function automatic logic is_nuc(char_t c);
		return (c == CHAR_A) || (c == CHAR_T) || (c == CHAR_C) || (c == CHAR_G);
	endfunction

	// Add a register value to a score, clamping to the signed score range.
	function automatic score_t sat_add(score_t a, reg_val_t b);
		logic signed [SCORE_BITS:0] sum;
		sum = {a[SCORE_BITS-1], a} + {{(SCORE_BITS+1-REG_BITS){b[REG_BITS-1]}}, b};
		if (sum[SCORE_BITS] != sum[SCORE_BITS-1]) begin
			return sum[SCORE_BITS] ? SCORE_MIN : SCORE_MAX;
		end
		return sum[SCORE_BITS-1:0];
	endfunction

	// Clamp a score to the signed output range.
	function automatic out_score_t out_sat(score_t x);
		cmp_score_t xe;
		cmp_score_t hi;
		cmp_score_t lo;
		xe = CMP_BITS'(x);
		hi = CMP_BITS'(OUT_MAX);
		lo = CMP_BITS'(OUT_MIN);
		if (xe > hi) begin
			return OUT_MAX;
		end
		if (xe < lo) begin
			return OUT_MIN;
		end
		return xe[OUT_BITS-1:0];
	endfunction

endpackage

>>> hw/rtl/tsacs_front.sv
// Front end of the column scorer: accepts columns, tracks the gap run and
// classifies the position score. Depends on tsacs_pkg.
module tsacs_front import tsacs_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	input  char_t   upper_char,
	input  char_t   lower_char,
	input  logic    first_column,
	input  logic    last_column,
	output logic    push_valid,
	input  logic    push_ready,
	output column_t push_item
);

	logic       in_gap_run_q;
	logic       gap_run_cur;
	logic       gap_run_next;
	logic       upper_gap;
	logic       lower_gap;
	pos_class_t pos_class;

	assign in_ready   = push_ready;
	assign push_valid = in_valid;

	// A first column starts from a cleared gap flag.
	assign gap_run_cur = first_column ? 1'b0 : in_gap_run_q;
	assign upper_gap   = (upper_char == CHAR_GAP);
	assign lower_gap   = (lower_char == CHAR_GAP);

	// Classify the column and work out the gap flag it leaves behind.
	always_comb begin
		gap_run_next = gap_run_cur;
		pos_class    = PC_ZERO;
		if (upper_gap && lower_gap) begin
			pos_class = PC_ZERO;
		end else if (upper_gap || lower_gap) begin
			pos_class    = gap_run_cur ? PC_GAP_EXTEND : PC_GAP_OPEN;
			gap_run_next = 1'b1;
		end else begin
			gap_run_next = 1'b0;
			if (is_nuc(upper_char) && is_nuc(lower_char)) begin
				pos_class = (upper_char == lower_char) ? PC_MATCH : PC_MISMATCH;
			end
		end
	end

	assign push_item.pos_class    = pos_class;
	assign push_item.first_column = first_column;
	assign push_item.last_column  = last_column;

	// The gap flag advances with every accepted item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_gap_run_q <= 1'b0;
		end else if (in_valid && push_ready) begin
			in_gap_run_q <= gap_run_next;
		end
	end

endmodule

>>> hw/rtl/tsacs_fifo.sv
// Short queue of classified columns between the front and back ends.
// Depends on tsacs_pkg.
module tsacs_fifo import tsacs_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push_valid,
	output logic    push_ready,
	input  column_t push_item,
	output logic    pop_valid,
	input  logic    pop_ready,
	output column_t pop_item
);

	column_t                  entry_q [FIFO_DEPTH];
	logic [FIFO_PTR_BITS-1:0] wr_ptr_q;
	logic [FIFO_PTR_BITS-1:0] rd_ptr_q;
	logic [FIFO_PTR_BITS:0]   count_q;
	logic                     do_push;
	logic                     do_pop;

	assign push_ready = (count_q != (FIFO_PTR_BITS+1)'(FIFO_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_item   = entry_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + FIFO_PTR_BITS'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + FIFO_PTR_BITS'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + (FIFO_PTR_BITS+1)'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - (FIFO_PTR_BITS+1)'(1);
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

>>> hw/rtl/tsacs_back.sv
// Back end of the column scorer: configuration registers, the two-state score
// recurrence and the output register. Depends on tsacs_pkg.
module tsacs_back import tsacs_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  cfg_wr_t    cfg,
	input  logic       pop_valid,
	output logic       pop_ready,
	input  column_t    pop_item,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       nc_from_state,
	output logic       cn_from_state,
	output out_score_t best_total,
	output logic       end_state,
	output logic       final_valid
);

	reg_val_t   cfg_q [NUM_REGS];
	score_t     nc_total_q;
	score_t     cn_total_q;
	score_t     nc_cur;
	score_t     cn_cur;
	score_t     nc_via_cn;
	score_t     cn_via_nc;
	score_t     new_nc;
	score_t     cn_best;
	score_t     new_cn;
	reg_val_t   pos_score;
	logic       nc_ptr;
	logic       cn_ptr;
	logic       advance;
	logic       do_pop;

	logic       valid_s1;
	logic       nc_ptr_s1;
	logic       cn_ptr_s1;
	logic       last_s1;
	score_t     new_nc_s1;
	score_t     new_cn_s1;

	logic       best_state;
	out_score_t best_sat;

	logic       out_valid_q;
	logic       nc_from_q;
	logic       cn_from_q;
	out_score_t best_q;
	logic       end_state_q;
	logic       final_q;

	// Configuration registers; writes beyond the last index are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q[REG_MATCH]      <= RESET_MATCH;
			cfg_q[REG_MISMATCH]   <= RESET_MISMATCH;
			cfg_q[REG_GAP_OPEN]   <= RESET_GAP_OPEN;
			cfg_q[REG_GAP_EXTEND] <= RESET_GAP_EXTEND;
			cfg_q[REG_ENTER_CN]   <= RESET_ENTER_CN;
			cfg_q[REG_LEAVE_CN]   <= RESET_LEAVE_CN;
		end else if (cfg.wr_en && (cfg.index < IDX_BITS'(NUM_REGS))) begin
			cfg_q[cfg.index] <= cfg.data;
		end
	end

	// Both stages move when the output register is free or being emptied.
	assign advance   = !out_valid_q || out_ready;
	assign pop_ready = advance;
	assign do_pop    = pop_valid && advance;

	// A first column starts both scores from zero.
	assign nc_cur = pop_item.first_column ? '0 : nc_total_q;
	assign cn_cur = pop_item.first_column ? '0 : cn_total_q;

	// Predecessor choice for both states; ties go to the non-conserved side.
	assign nc_via_cn = sat_add(cn_cur, cfg_q[REG_LEAVE_CN]);
	assign cn_via_nc = sat_add(nc_cur, cfg_q[REG_ENTER_CN]);
	assign nc_ptr    = !(nc_cur >= nc_via_cn);
	assign cn_ptr    = !(cn_via_nc >= cn_cur);
	assign new_nc    = nc_ptr ? nc_via_cn : nc_cur;
	assign cn_best   = cn_ptr ? cn_cur : cn_via_nc;

	// Position score selected by the class the front end resolved.
	always_comb begin
		unique case (pop_item.pos_class)
			PC_GAP_OPEN:   pos_score = cfg_q[REG_GAP_OPEN];
			PC_GAP_EXTEND: pos_score = cfg_q[REG_GAP_EXTEND];
			PC_MATCH:      pos_score = cfg_q[REG_MATCH];
			PC_MISMATCH:   pos_score = cfg_q[REG_MISMATCH];
			default:       pos_score = '0;
		endcase
	end

	assign new_cn = sat_add(cn_best, pos_score);

	// Running scores.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nc_total_q <= '0;
			cn_total_q <= '0;
		end else if (do_pop) begin
			nc_total_q <= new_nc;
			cn_total_q <= new_cn;
		end
	end

	// Recurrence stage register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= pop_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (do_pop) begin
			nc_ptr_s1 <= nc_ptr;
			cn_ptr_s1 <= cn_ptr;
			last_s1   <= pop_item.last_column;
			new_nc_s1 <= new_nc;
			new_cn_s1 <= new_cn;
		end
	end

	// Final score: the better state, ties to non-conserved, clamped to output width.
	assign best_state = !(new_nc_s1 >= new_cn_s1);
	assign best_sat   = out_sat(best_state ? new_cn_s1 : new_nc_s1);

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			nc_from_q   <= nc_ptr_s1;
			cn_from_q   <= cn_ptr_s1;
			final_q     <= last_s1;
			best_q      <= last_s1 ? best_sat : '0;
			end_state_q <= last_s1 && best_state;
		end
	end

	assign out_valid     = out_valid_q;
	assign nc_from_state = nc_from_q;
	assign cn_from_state = cn_from_q;
	assign best_total    = best_q;
	assign end_state     = end_state_q;
	assign final_valid   = final_q;

endmodule

>>> hw/rtl/two_state_alignment_column_scorer_top.sv
// Two-state alignment column scorer. Each input item is one alignment column;
// each column yields one result item carrying the predecessor bits of the
// non-conserved and conserved scores, and on a last column the best total and
// its state. The block takes one column per clock cycle, sustained, as long as
// results are taken; the rate is set by the score recurrence in the back end,
// which works out both new running scores combinationally and registers them
// for each column it takes. A column passes a queue entry and the recurrence
// stage register, and its result is presented from the output register. A
// four-entry queue between the classifier and the recurrence keeps accepting
// columns while results are held up, until it is full.
// Depends on tsacs_pkg, tsacs_front, tsacs_fifo and tsacs_back.
module two_state_alignment_column_scorer_top import tsacs_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [15:0]         s_tdata,    // [7:0] upper_char, [15:8] lower_char
	input  logic                s_tuser,    // [0] first_column
	input  logic                s_tlast,    // last_column
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [39:0]         m_tdata,    // [0] nc_from_state, [1] cn_from_state,
	                                        // [33:2] best_total, [34] end_state, rest zero
	output logic                m_tlast,    // final_valid
	input  logic                cfg_wr_en,
	input  logic [IDX_BITS-1:0] cfg_index,
	input  logic [REG_BITS-1:0] cfg_data
);

	logic       push_valid;
	logic       push_ready;
	column_t    push_item;
	logic       pop_valid;
	logic       pop_ready;
	column_t    pop_item;
	cfg_wr_t    cfg;
	logic       nc_from_state;
	logic       cn_from_state;
	out_score_t best_total;
	logic       end_state;

	assign cfg.wr_en = cfg_wr_en;
	assign cfg.index = cfg_index;
	assign cfg.data  = cfg_data;

	tsacs_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (s_tvalid),
		.in_ready     (s_tready),
		.upper_char   (s_tdata[7:0]),
		.lower_char   (s_tdata[15:8]),
		.first_column (s_tuser),
		.last_column  (s_tlast),
		.push_valid   (push_valid),
		.push_ready   (push_ready),
		.push_item    (push_item)
	);

	tsacs_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_item   (pop_item)
	);

	tsacs_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg),
		.pop_valid     (pop_valid),
		.pop_ready     (pop_ready),
		.pop_item      (pop_item),
		.out_valid     (m_tvalid),
		.out_ready     (m_tready),
		.nc_from_state (nc_from_state),
		.cn_from_state (cn_from_state),
		.best_total    (best_total),
		.end_state     (end_state),
		.final_valid   (m_tlast)
	);

	assign m_tdata = {5'd0, end_state, best_total, cn_from_state, nc_from_state};

endmodule

>>> hw/rtl/tsacs_checker.sv
// Port-level checker for the alignment column scorer, bound to the top level.
// Depends on the assertion macros header.
`include "two_state_alignment_column_scorer_top_defines.svh"

module tsacs_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [39:0] m_tdata,
	input logic        m_tlast
);

	// A stalled result keeps its contents.
	`TSACS_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast), "result changed while stalled")

	// Only a last column's result carries a total and end state.
	`TSACS_ASSERT_IMP(a_total_only_last, m_tvalid && !m_tlast, m_tdata[34:2] == 33'd0, "total on a column that is not last")

	// Padding bits above the packed fields stay clear.
	`TSACS_ASSERT_IMP(a_pad_zero, m_tvalid, m_tdata[39:35] == 5'd0, "padding bits set in result")

	// The queue only fills up behind a result that is waiting to be taken.
	`TSACS_ASSERT_IMP(a_full_needs_stall, !s_tready, m_tvalid, "input stalled with no result pending")

endmodule

bind two_state_alignment_column_scorer_top tsacs_checker u_tsacs_checker (.*);

>>> verif/tb_two_state_alignment_column_scorer_top.sv
// Self-checking testbench for the two-state alignment column scorer top level.
// It streams alignment columns, scores them with its own recurrence and checks
// every result item field by field. Depends on tsacs_pkg and the scorer RTL.
module tb_two_state_alignment_column_scorer_top;
	import tsacs_pkg::*;

	localparam int CYCLE_LIMIT      = 500000;
	localparam int DRAIN_CYCLES     = 8;
	localparam int NUM_BLOCKS       = 6;
	localparam int RANDOM_PER_BLOCK = 240;

	// Register indexes past the last register; writes to them are dropped.
	localparam logic [IDX_BITS-1:0] IDX_SPARE_LO = 3'd6;
	localparam logic [IDX_BITS-1:0] IDX_SPARE_HI = 3'd7;

	// Characters that are neither gaps nor uppercase bases.
	localparam char_t CHAR_N        = 8'h4E;
	localparam char_t CHAR_LOWER_A  = 8'h61;
	localparam char_t CHAR_LOWER_Z  = 8'h7A;
	localparam char_t CHAR_ALL_ONES = 8'hFF;
	localparam char_t CHAR_NUL      = 8'h00;

	typedef struct {
		char_t upper;
		char_t lower;
		logic  first;
		logic  last;
		logic  hold;
	} column_item_t;

	typedef struct {
		logic       nc_from;
		logic       cn_from;
		out_score_t best;
		logic       end_st;
		logic       final_col;
	} column_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [15:0] s_tdata = '0;
	logic s_tuser = 1'b0;
	logic s_tlast = 1'b0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [39:0] m_tdata;
	logic m_tlast;
	logic cfg_wr_en = 1'b0;
	logic [IDX_BITS-1:0] cfg_index = '0;
	logic [REG_BITS-1:0] cfg_data = '0;

	column_item_t columns_to_send[$];
	column_result_t results_due[$];
	column_item_t on_bus;

	int unsigned send_idle_pct = 17;
	int unsigned recv_idle_pct = 74;
	int unsigned cycle_count = 0;
	int error_count = 0;

	// Scoring state mirrored from the block.
	reg_val_t score_regs [NUM_REGS];
	score_t nc_score = '0;
	score_t cn_score = '0;
	logic gap_run = 1'b0;

	two_state_alignment_column_scorer_top uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Cycle counter and run timeout.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb_two_state_alignment_column_scorer_top failed");
			$finish;
		end
	end

	task automatic report_mismatch(string what);
		$display("MISMATCH cycle %0d: %s", cycle_count, what);
		error_count++;
	endtask

	function automatic score_t clamp_add(score_t a, reg_val_t b);
		longint sum;
		sum = longint'(a) + longint'(b);
		if (sum > longint'(SCORE_MAX)) begin
			return SCORE_MAX;
		end
		if (sum < longint'(SCORE_MIN)) begin
			return SCORE_MIN;
		end
		return score_t'(sum);
	endfunction

	function automatic logic is_base(char_t c);
		return (c == CHAR_A) || (c == CHAR_C) || (c == CHAR_G) || (c == CHAR_T);
	endfunction

	// Score a column earns in the conserved state; also tracks the gap run.
	function automatic reg_val_t position_bonus(char_t u, char_t l);
		logic u_gap;
		logic l_gap;
		u_gap = (u == CHAR_GAP);
		l_gap = (l == CHAR_GAP);
		if (u_gap && l_gap) begin
			return '0;
		end
		if (u_gap || l_gap) begin
			if (gap_run) begin
				return score_regs[REG_GAP_EXTEND];
			end
			gap_run = 1'b1;
			return score_regs[REG_GAP_OPEN];
		end
		gap_run = 1'b0;
		if (is_base(u) && is_base(l)) begin
			return (u == l) ? score_regs[REG_MATCH] : score_regs[REG_MISMATCH];
		end
		return '0;
	endfunction

	// One step of the two-state recurrence; ties go to the non-conserved side.
	function automatic column_result_t score_column(column_item_t col);
		column_result_t res;
		score_t from_cn;
		score_t from_nc;
		score_t next_nc;
		score_t next_cn;
		longint best;
		if (col.first) begin
			nc_score = '0;
			cn_score = '0;
			gap_run = 1'b0;
		end
		from_cn = clamp_add(cn_score, score_regs[REG_LEAVE_CN]);
		res.nc_from = (from_cn > nc_score);
		next_nc = res.nc_from ? from_cn : nc_score;
		from_nc = clamp_add(nc_score, score_regs[REG_ENTER_CN]);
		res.cn_from = (cn_score > from_nc);
		next_cn = res.cn_from ? cn_score : from_nc;
		next_cn = clamp_add(next_cn, position_bonus(col.upper, col.lower));
		nc_score = next_nc;
		cn_score = next_cn;
		res.best = '0;
		res.end_st = 1'b0;
		res.final_col = col.last;
		if (col.last) begin
			res.end_st = (next_cn > next_nc);
			best = longint'(res.end_st ? next_cn : next_nc);
			if (best > longint'(OUT_MAX)) begin
				best = longint'(OUT_MAX);
			end
			if (best < longint'(OUT_MIN)) begin
				best = longint'(OUT_MIN);
			end
			res.best = out_score_t'(best);
		end
		return res;
	endfunction

	// Column driver: scores each item as it is accepted, then offers the next.
	always @(posedge clk) begin : column_driver
		logic busy;
		if (arst_n) begin
			busy = s_tvalid;
			if (s_tvalid && s_tready) begin
				results_due.insert(results_due.size(), score_column(on_bus));
				busy = 1'b0;
			end
			if (!busy) begin
				if (columns_to_send.size() != 0
				    && !(columns_to_send[0].hold && results_due.size() != 0)
				    && $urandom_range(99) >= send_idle_pct) begin
					on_bus = columns_to_send.pop_front();
					s_tdata <= {on_bus.lower, on_bus.upper};
					s_tuser <= on_bus.first;
					s_tlast <= on_bus.last;
					s_tvalid <= 1'b1;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Result side backpressure.
	always @(posedge clk) begin
		if (arst_n) begin
			m_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Result monitor: compares each item with the oldest expectation.
	always @(posedge clk) begin : result_check
		column_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (results_due.size() == 0) begin
				report_mismatch("result item arrived with nothing expected");
			end else begin
				want = results_due.pop_front();
				if (m_tdata[0] !== want.nc_from) begin
					report_mismatch($sformatf("nc_from_state got %b want %b",
						m_tdata[0], want.nc_from));
				end
				if (m_tdata[1] !== want.cn_from) begin
					report_mismatch($sformatf("cn_from_state got %b want %b",
						m_tdata[1], want.cn_from));
				end
				if (m_tdata[33:2] !== want.best) begin
					report_mismatch($sformatf("best_total got %0d want %0d",
						$signed(m_tdata[33:2]), want.best));
				end
				if (m_tdata[34] !== want.end_st) begin
					report_mismatch($sformatf("end_state got %b want %b",
						m_tdata[34], want.end_st));
				end
				if (m_tlast !== want.final_col) begin
					report_mismatch($sformatf("final_valid got %b want %b",
						m_tlast, want.final_col));
				end
				if (m_tdata[39:35] !== 5'd0) begin
					report_mismatch($sformatf("padding bits got %b", m_tdata[39:35]));
				end
			end
		end
	end

	function automatic column_item_t make_column(char_t u, char_t l, logic f, logic la);
		column_item_t col;
		col.upper = u;
		col.lower = l;
		col.first = f;
		col.last = la;
		col.hold = 1'b0;
		return col;
	endfunction

	// Appends one column to the end of the pending list.
	task automatic add_column(column_item_t col);
		columns_to_send.insert(columns_to_send.size(), col);
	endtask

	function automatic char_t random_base();
		case ($urandom_range(3))
			0: return CHAR_A;
			1: return CHAR_C;
			2: return CHAR_G;
			default: return CHAR_T;
		endcase
	endfunction

	// Mostly bases and gaps, with some lowercase and arbitrary bytes.
	function automatic column_item_t random_column(logic f, logic la);
		int unsigned roll;
		char_t u;
		char_t l;
		roll = $urandom_range(99);
		if (roll < 45) begin
			u = random_base();
			l = $urandom_range(1) ? u : random_base();
		end else if (roll < 70) begin
			u = CHAR_GAP;
			l = $urandom_range(4) ? random_base() : char_t'($urandom_range(255));
			if ($urandom_range(1)) begin
				l = u;
				u = $urandom_range(4) ? random_base() : char_t'($urandom_range(255));
			end
		end else if (roll < 80) begin
			u = CHAR_GAP;
			l = CHAR_GAP;
		end else if (roll < 90) begin
			u = char_t'($urandom_range(CHAR_LOWER_A, CHAR_LOWER_Z));
			l = $urandom_range(1) ? u : random_base();
		end else begin
			u = char_t'($urandom_range(255));
			l = char_t'($urandom_range(255));
		end
		return make_column(u, l, f, la);
	endfunction

	// Whole alignments with random content, plus some columns with random flags.
	task automatic add_random_columns(int count, logic with_hold);
		int added;
		int len;
		int k;
		int hold_at;
		column_item_t col;
		added = 0;
		hold_at = $urandom_range(count / 2);
		while (added < count) begin
			if ($urandom_range(99) < 85) begin
				len = ($urandom_range(9) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 16);
				for (k = 0; k < len; k++) begin
					col = random_column(k == 0, k == len - 1);
					col.hold = with_hold && (added == hold_at);
					add_column(col);
					added++;
				end
			end else begin
				col = random_column(1'($urandom_range(1)), 1'($urandom_range(1)));
				col.hold = with_hold && (added == hold_at);
				add_column(col);
				added++;
			end
		end
	endtask

	task automatic add_directed_columns();
		// Matches of every base, then mismatches.
		add_column(make_column(CHAR_A, CHAR_A, 1'b1, 1'b0));
		add_column(make_column(CHAR_C, CHAR_C, 1'b0, 1'b0));
		add_column(make_column(CHAR_G, CHAR_G, 1'b0, 1'b0));
		add_column(make_column(CHAR_T, CHAR_T, 1'b0, 1'b0));
		add_column(make_column(CHAR_A, CHAR_T, 1'b0, 1'b0));
		add_column(make_column(CHAR_G, CHAR_C, 1'b0, 1'b0));
		// Gap run: open, extend, gap against gap keeps the run, extend again.
		add_column(make_column(CHAR_GAP, CHAR_A, 1'b0, 1'b0));
		add_column(make_column(CHAR_T, CHAR_GAP, 1'b0, 1'b0));
		add_column(make_column(CHAR_GAP, CHAR_GAP, 1'b0, 1'b0));
		add_column(make_column(CHAR_GAP, CHAR_G, 1'b0, 1'b0));
		add_column(make_column(CHAR_A, CHAR_A, 1'b0, 1'b0));
		add_column(make_column(CHAR_C, CHAR_GAP, 1'b0, 1'b0));
		// Non-gap characters that are not uppercase bases score nothing.
		add_column(make_column(CHAR_LOWER_A, CHAR_LOWER_A, 1'b0, 1'b0));
		add_column(make_column(CHAR_N, CHAR_N, 1'b0, 1'b0));
		add_column(make_column(CHAR_ALL_ONES, CHAR_NUL, 1'b0, 1'b0));
		add_column(make_column(CHAR_NUL, CHAR_ALL_ONES, 1'b0, 1'b0));
		add_column(make_column(CHAR_A, CHAR_C, 1'b0, 1'b1));
		// Columns after a last column without a new first column carry on.
		add_column(make_column(CHAR_G, CHAR_G, 1'b0, 1'b0));
		add_column(make_column(CHAR_GAP, CHAR_T, 1'b0, 1'b1));
		// One-column alignments, then a two-column one.
		add_column(make_column(CHAR_T, CHAR_T, 1'b1, 1'b1));
		add_column(make_column(CHAR_GAP, CHAR_GAP, 1'b1, 1'b1));
		add_column(make_column(CHAR_C, CHAR_A, 1'b1, 1'b0));
		add_column(make_column(CHAR_A, CHAR_GAP, 1'b0, 1'b1));
	endtask

	task automatic write_reg(logic [IDX_BITS-1:0] idx, reg_val_t val);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		if (idx < NUM_REGS) begin
			score_regs[idx] = val;
		end
	endtask

	task automatic load_settings(int block);
		case (block)
			1: begin
				write_reg(REG_MATCH, 16'sh7FFF);
				write_reg(REG_MISMATCH, 16'sh7FFF);
				write_reg(REG_GAP_OPEN, 16'sh7FFF);
				write_reg(REG_GAP_EXTEND, 16'sh7FFF);
				write_reg(REG_ENTER_CN, 16'sh7FFF);
				write_reg(REG_LEAVE_CN, 16'sh7FFF);
				write_reg(IDX_SPARE_LO, reg_val_t'($urandom_range(65535)));
				write_reg(IDX_SPARE_HI, reg_val_t'($urandom_range(65535)));
			end
			2: begin
				write_reg(REG_MATCH, 16'sh8000);
				write_reg(REG_MISMATCH, 16'sh8000);
				write_reg(REG_GAP_OPEN, 16'sh8000);
				write_reg(REG_GAP_EXTEND, 16'sh8000);
				write_reg(REG_ENTER_CN, 16'sh8000);
				write_reg(REG_LEAVE_CN, 16'sh8000);
			end
			3: begin
				write_reg(REG_MATCH, reg_val_t'($urandom_range(65535)));
				write_reg(REG_MISMATCH, reg_val_t'($urandom_range(65535)));
				write_reg(REG_GAP_OPEN, reg_val_t'($urandom_range(65535)));
				write_reg(REG_GAP_EXTEND, reg_val_t'($urandom_range(65535)));
				write_reg(REG_ENTER_CN, reg_val_t'($urandom_range(65535)));
				write_reg(REG_LEAVE_CN, reg_val_t'($urandom_range(65535)));
			end
			4: begin
				// All zero: every choice is a tie.
				write_reg(REG_MATCH, '0);
				write_reg(REG_MISMATCH, '0);
				write_reg(REG_GAP_OPEN, '0);
				write_reg(REG_GAP_EXTEND, '0);
				write_reg(REG_ENTER_CN, '0);
				write_reg(REG_LEAVE_CN, '0);
			end
			default: begin
				write_reg(REG_MATCH, 16'sh7FFF);
				write_reg(REG_MISMATCH, 16'sh8000);
				write_reg(REG_GAP_OPEN, 16'sh8000);
				write_reg(REG_GAP_EXTEND, 16'sh7FFF);
				write_reg(REG_ENTER_CN, reg_val_t'($urandom_range(65535)));
				write_reg(REG_LEAVE_CN, reg_val_t'($urandom_range(65535)));
			end
		endcase
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// Settles at the falling edge so the driver's and monitor's updates are in.
	task automatic wait_until_idle();
		while (columns_to_send.size() != 0 || s_tvalid || results_due.size() != 0) begin
			@(negedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Main sequence: reset, directed columns, then blocks of random columns,
	// each under its own register setting, and pairs of blocks share an idle pattern.
	initial begin : stimulus
		int block;
		score_regs[REG_MATCH] = RESET_MATCH;
		score_regs[REG_MISMATCH] = RESET_MISMATCH;
		score_regs[REG_GAP_OPEN] = RESET_GAP_OPEN;
		score_regs[REG_GAP_EXTEND] = RESET_GAP_EXTEND;
		score_regs[REG_ENTER_CN] = RESET_ENTER_CN;
		score_regs[REG_LEAVE_CN] = RESET_LEAVE_CN;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		add_directed_columns();
		for (block = 0; block < NUM_BLOCKS; block++) begin
			if (block != 0) begin
				wait_until_idle();
				load_settings(block);
			end
			if (block < 2) begin
				send_idle_pct <= 17;
				recv_idle_pct <= 74;
			end else if (block < 4) begin
				send_idle_pct <= 74;
				recv_idle_pct <= 17;
			end else begin
				send_idle_pct <= 0;
				recv_idle_pct <= 0;
			end
			add_random_columns(RANDOM_PER_BLOCK, block == 2 || block == 4);
		end
		wait_until_idle();
		if (error_count == 0) begin
			$display("tb_two_state_alignment_column_scorer_top passed");
		end else begin
			$display("tb_two_state_alignment_column_scorer_top failed");
		end
		$finish;
	end

endmodule

>>> sim.f
+incdir+hw/rtl
hw/rtl/tsacs_pkg.sv
hw/rtl/tsacs_front.sv
hw/rtl/tsacs_fifo.sv
hw/rtl/tsacs_back.sv
hw/rtl/two_state_alignment_column_scorer_top.sv
hw/rtl/tsacs_checker.sv
verif/tb_two_state_alignment_column_scorer_top.sv
